// File: hdl/dlh_pkg.sv
// Shared types, opcodes and constants of the delta run-length histogram.
`default_nettype none
package dlh_pkg;

    localparam int DEF_NUM_VALUES  = 256;
    localparam int DEF_COORD_WIDTH = 32;

    localparam logic [15:0] MIN_RUN_RESET = 16'd4;
    localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;

    localparam logic [1:0] OP_POINT = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] row_index;
        logic [31:0] col_index;
        logic [7:0]  entry_index;
    } in_t;

    typedef struct packed {
        logic [31:0] run_count;
        logic [31:0] run_total;
        logic        value_overflow;
    } out_t;

    // Request from the run tracker to the histogram table.
    typedef struct packed {
        logic upd;       // add a closed run to the entry
        logic rd;        // read the entry
        logic clr;       // clear every entry
        logic in_range;  // read index lies inside the table
        logic ovf;       // sticky overflow flag as seen by this transaction
    } ctl_t;

endpackage
`default_nettype wire

// File: hdl/dlh_stream.sv
// Run tracker: delta encoding, run detection, overflow flag and the length register.
`default_nettype none
module dlh_stream #(
    parameter int NUM_VALUES  = dlh_pkg::DEF_NUM_VALUES,
    parameter int COORD_WIDTH = dlh_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [15:0]                    cfg_wr_data,
    input  wire logic                           accept,
    input  wire dlh_pkg::in_t                   item,
    output dlh_pkg::ctl_t                       req_ctl,
    output logic [$clog2(NUM_VALUES)-1:0]       req_addr,
    output logic [31:0]                         req_len
);
    import dlh_pkg::*;

    localparam int AW = $clog2(NUM_VALUES);
    localparam int CW = COORD_WIDTH;
    localparam logic [64:0] NV_EXT  = 65'(NUM_VALUES);
    localparam logic [15:0] NV_ENT  = 16'(NUM_VALUES);

    logic [15:0]   min_len_reg;
    logic [CW-1:0] last_row_reg, last_row_next;
    logic [CW-1:0] last_col_reg, last_col_next;
    logic          row_open_reg, row_open_next;
    logic [CW-1:0] run_value_reg, run_value_next;
    logic [31:0]   run_len_reg, run_len_next;
    logic          ovf_reg, ovf_next;

    logic [CW-1:0] row_c, col_c, delta;
    logic [64:0]   val_ext;
    logic [15:0]   ent_ext;
    logic          open_eff, close, record, in_tab, is_read, is_clear;

    assign row_c   = CW'(item.row_index);
    assign col_c   = CW'(item.col_index);
    assign delta   = col_c - last_col_reg;
    assign val_ext = 65'(run_value_reg);
    assign ent_ext = 16'(item.entry_index);
    assign in_tab  = val_ext < NV_EXT;

    always_comb begin
        last_row_next  = last_row_reg;
        last_col_next  = last_col_reg;
        row_open_next  = row_open_reg;
        run_value_next = run_value_reg;
        run_len_next   = run_len_reg;
        ovf_next       = ovf_reg;
        open_eff       = 1'b0;
        close          = 1'b0;
        is_read        = 1'b0;
        is_clear       = 1'b0;
        if (accept) begin
            case (item.opcode)
                OP_POINT: begin
                    // A row change closes the open run; the point then opens a new row.
                    if (row_open_reg && row_c != last_row_reg) begin
                        close = 1'b1;
                    end
                    open_eff      = row_open_reg && (row_c == last_row_reg);
                    last_row_next = row_c;
                    last_col_next = col_c;
                    row_open_next = 1'b1;
                    if (!open_eff) begin
                        run_value_next = col_c;
                        run_len_next   = 32'd1;
                    end else if (delta == run_value_reg) begin
                        if (run_len_reg != SAT32) begin
                            run_len_next = run_len_reg + 32'd1;
                        end
                    end else begin
                        close          = 1'b1;
                        run_value_next = delta;
                        run_len_next   = 32'd1;
                    end
                end
                OP_FLUSH: begin
                    close         = row_open_reg;
                    row_open_next = 1'b0;
                end
                OP_READ: begin
                    is_read = 1'b1;
                end
                OP_CLEAR: begin
                    is_clear       = 1'b1;
                    last_row_next  = CW'(1);
                    last_col_next  = '0;
                    row_open_next  = 1'b0;
                    run_value_next = '0;
                    run_len_next   = '0;
                end
                default: begin
                    is_read = 1'b0;
                end
            endcase
        end
        record = close && (run_len_reg >= 32'(min_len_reg));
        if (record && !in_tab) begin
            ovf_next = 1'b1;
        end
        if (is_clear) begin
            ovf_next = 1'b0;
        end
    end

    assign req_ctl.upd      = record && in_tab;
    assign req_ctl.rd       = is_read;
    assign req_ctl.clr      = is_clear;
    assign req_ctl.in_range = ent_ext < NV_ENT;
    assign req_ctl.ovf      = ovf_reg;
    assign req_addr = is_read ? ent_ext[AW-1:0] : val_ext[AW-1:0];
    assign req_len  = run_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg   <= MIN_RUN_RESET;
            last_row_reg  <= CW'(1);
            last_col_reg  <= '0;
            row_open_reg  <= 1'b0;
            run_value_reg <= '0;
            run_len_reg   <= '0;
            ovf_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                min_len_reg <= cfg_wr_data;
            end
            last_row_reg  <= last_row_next;
            last_col_reg  <= last_col_next;
            row_open_reg  <= row_open_next;
            run_value_reg <= run_value_next;
            run_len_reg   <= run_len_next;
            ovf_reg       <= ovf_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/dlh_table.sv
// Histogram memory with read-modify-write, write-back forwarding and per-entry valid bits.
`default_nettype none
module dlh_table #(
    parameter int NUM_VALUES = dlh_pkg::DEF_NUM_VALUES
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dlh_pkg::ctl_t                  req_ctl,
    input  wire logic [$clog2(NUM_VALUES)-1:0]  req_addr,
    input  wire logic [31:0]                    req_len,
    output logic                                rd_pending,
    output logic                                res_push,
    output dlh_pkg::out_t                       res_data
);
    import dlh_pkg::*;

    localparam int AW = $clog2(NUM_VALUES);

    logic [63:0]           hist_mem [NUM_VALUES];
    logic [63:0]           rd_data_reg;
    logic [NUM_VALUES-1:0] valid_reg;

    ctl_t                  p1_ctl_reg;
    logic [AW-1:0]         p1_addr_reg;
    logic [31:0]           p1_len_reg;

    logic                  wb_valid_reg;
    logic [AW-1:0]         wb_addr_reg;
    logic [63:0]           wb_data_reg;

    logic [63:0]           base;
    logic [31:0]           base_cnt, base_tot, cnt_new, tot_new;
    logic [32:0]           tot_sum;
    logic                  wr_en;
    logic [63:0]           wr_data;

    // The entry written at the previous edge is not yet in the read data.
    always_comb begin
        if (wb_valid_reg && wb_addr_reg == p1_addr_reg) begin
            base = wb_data_reg;
        end else if (valid_reg[p1_addr_reg]) begin
            base = rd_data_reg;
        end else begin
            base = '0;
        end
    end

    assign base_cnt = base[63:32];
    assign base_tot = base[31:0];
    assign cnt_new  = (base_cnt == SAT32) ? base_cnt : base_cnt + 32'd1;
    assign tot_sum  = {1'b0, base_tot} + {1'b0, p1_len_reg};
    assign tot_new  = (tot_sum >= {1'b0, SAT32}) ? SAT32 : tot_sum[31:0];
    assign wr_en    = p1_ctl_reg.upd;
    assign wr_data  = {cnt_new, tot_new};

    assign rd_pending              = p1_ctl_reg.rd;
    assign res_push                = p1_ctl_reg.rd;
    assign res_data.run_count      = p1_ctl_reg.in_range ? base_cnt : 32'd0;
    assign res_data.run_total      = p1_ctl_reg.in_range ? base_tot : 32'd0;
    assign res_data.value_overflow = p1_ctl_reg.ovf;

    always_ff @(posedge aclk) begin
        rd_data_reg <= hist_mem[req_addr];
        if (wr_en) begin
            hist_mem[p1_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        p1_addr_reg <= req_addr;
        p1_len_reg  <= req_len;
        wb_addr_reg <= p1_addr_reg;
        wb_data_reg <= wr_data;
        if (!aresetn) begin
            p1_ctl_reg   <= '0;
            wb_valid_reg <= 1'b0;
            valid_reg    <= '0;
        end else begin
            p1_ctl_reg   <= req_ctl;
            wb_valid_reg <= wr_en && !req_ctl.clr;
            // A clear in the same cycle as a write wins over the write.
            if (req_ctl.clr) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[p1_addr_reg] <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/dlh_out_fifo.sv
// Small result queue that decouples the histogram pipeline from the result channel.
`default_nettype none
module dlh_out_fifo (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              push,
    input  wire dlh_pkg::out_t                     push_data,
    output logic [dlh_pkg::FIFO_CNT_W-1:0]         fill,
    output logic                                   pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output dlh_pkg::out_t                          m_data
);
    import dlh_pkg::*;

    out_t                  entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;

    assign m_valid = cnt_reg != '0;
    assign m_data  = entries[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign fill    = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/delta_run_length_histogram.sv
// Throughput: one transaction of any opcode per cycle; s_ready drops only while the result
// queue, counting a read still in the memory stage, has no free entry.
// A read is answered on m_valid after the memory read register and then the queue register;
// updates write the memory from the memory stage register, forwarded.
// Reset is synchronous: stream state clears, min_run_length returns to 4, and all histogram
// entries read as zero at once through per-entry valid bits, with no clearing pass.
`default_nettype none
module delta_run_length_histogram #(
    parameter int NUM_VALUES  = dlh_pkg::DEF_NUM_VALUES,
    parameter int COORD_WIDTH = dlh_pkg::DEF_COORD_WIDTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [15:0]    cfg_wr_data,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire dlh_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output dlh_pkg::out_t       m_data
);
    import dlh_pkg::*;

    localparam int AW = $clog2(NUM_VALUES);

    logic                  accept;
    ctl_t                  req_ctl;
    logic [AW-1:0]         req_addr;
    logic [31:0]           req_len;
    logic                  rd_pending;
    logic                  res_push;
    out_t                  res_data;
    logic [FIFO_CNT_W-1:0] fifo_fill;
    logic                  fifo_pop;

    // Space is reserved in the queue for a read still in the memory stage.
    assign s_ready = ({1'b0, fifo_fill} + {{FIFO_CNT_W{1'b0}}, rd_pending})
                     <= (FIFO_CNT_W + 1)'(FIFO_DEPTH - 1);
    assign accept  = s_valid && s_ready;

    dlh_stream #(
        .NUM_VALUES  (NUM_VALUES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_stream (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item        (s_data),
        .req_ctl     (req_ctl),
        .req_addr    (req_addr),
        .req_len     (req_len)
    );

    dlh_table #(
        .NUM_VALUES (NUM_VALUES)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_ctl    (req_ctl),
        .req_addr   (req_addr),
        .req_len    (req_len),
        .rd_pending (rd_pending),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    dlh_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .fill      (fifo_fill),
        .pop       (fifo_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef ASSERT_OFF
    a_fifo_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_push && !fifo_pop && fifo_fill == FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_read_enters_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.opcode == OP_READ) |=> rd_pending)
        else $error("accepted read did not reach the memory stage");

    a_clear_drops_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.opcode == OP_CLEAR) |=> !req_ctl.ovf)
        else $error("overflow flag survived a clear");
`endif

endmodule
`default_nettype wire

// File: test/delta_run_length_histogram_tb.sv
// Self-checking testbench for the delta run-length histogram: directed table, then random streams.
`timescale 1ns / 1ps

module delta_run_length_histogram_tb;
    import dlh_pkg::*;

    localparam int NUM_VALUES    = DEF_NUM_VALUES;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_ITEMS   = 232;
    localparam int N_DIRECTED    = 24;

    typedef struct packed {
        in_t  item;
        logic fixed;   // compare against the typed-in result instead of the predictor
        out_t want;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{OP_READ,  32'd0, 32'd0, 8'd0},   1'b1, '{32'd0, 32'd0, 1'b0}},
        '{'{OP_READ,  32'd0, 32'd0, 8'd255}, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{'{OP_POINT, 32'd1, 32'd3, 8'd0},   1'b0, '0},
        '{'{OP_POINT, 32'd1, 32'd6, 8'd0},   1'b0, '0},
        '{'{OP_POINT, 32'd1, 32'd9, 8'd0},   1'b0, '0},
        '{'{OP_POINT, 32'd1, 32'd12, 8'd0},  1'b0, '0},
        '{'{OP_POINT, 32'd2, 32'd5, 8'd0},   1'b0, '0},
        '{'{OP_READ,  32'd0, 32'd0, 8'd3},   1'b0, '0},
        '{'{OP_POINT, 32'd2, 32'd5, 8'd0},   1'b0, '0},
        '{'{OP_POINT, 32'd2, 32'd4, 8'd0},   1'b0, '0},
        '{'{OP_POINT, 32'd2, 32'd3, 8'd0},   1'b0, '0},
        '{'{OP_POINT, 32'd2, 32'd2, 8'd0},   1'b0, '0},
        '{'{OP_POINT, 32'd2, 32'd1, 8'd0},   1'b0, '0},
        '{'{OP_FLUSH, 32'd0, 32'd0, 8'd0},   1'b0, '0},
        '{'{OP_FLUSH, 32'd0, 32'd0, 8'd0},   1'b0, '0},
        '{'{OP_READ,  32'd0, 32'd0, 8'd0},   1'b0, '0},
        '{'{OP_POINT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 1'b0, '0},
        '{'{OP_POINT, 32'd0, 32'd0, 8'd0},   1'b0, '0},
        '{'{OP_POINT, 32'd0, 32'hFFFF_FFFF, 8'd0}, 1'b0, '0},
        '{'{OP_POINT, 32'd0, 32'hFFFF_FFFE, 8'd0}, 1'b0, '0},
        '{'{OP_FLUSH, 32'd0, 32'd0, 8'd0},   1'b0, '0},
        '{'{OP_READ,  32'd0, 32'd0, 8'd128}, 1'b0, '0},
        '{'{OP_CLEAR, 32'd0, 32'd0, 8'd0},   1'b0, '0},
        '{'{OP_READ,  32'd0, 32'd0, 8'd3},   1'b1, '{32'd0, 32'd0, 1'b0}}
    };

    localparam logic [15:0] MIN_LEN_SETTINGS [NUM_PHASES] = '{
        16'd1, 16'd0, 16'd65535, 16'd2, 16'd4, 16'd3, 16'd6
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready = 1'b1;
    out_t        m_data;

    delta_run_length_histogram u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // Histogram state as the block should hold it.
    logic [15:0] min_len;
    logic [31:0] last_row;
    logic [31:0] last_col;
    logic        row_open;
    logic [31:0] run_value;
    logic [31:0] run_length;
    logic        overflow_flag;
    logic [31:0] count_table [NUM_VALUES];
    logic [31:0] total_table [NUM_VALUES];
    out_t        expected_reads [$];

    // Random stream generator state.
    logic [31:0] gen_row = 32'd1;
    logic [31:0] gen_col = 32'd0;
    logic [31:0] gen_delta = 32'd0;
    int          gen_left = 0;

    bit          gaps_on;
    bit          stall_on;
    int          burst_left = 0;
    logic [15:0] rx_pattern = 16'hFFFF;
    logic [5:0]  rx_tick = '0;
    int          idle_cycles = 0;

    int          err_count = 0;
    int          n_items = 0;
    int          n_reads = 0;
    int          n_recorded = 0;
    int          n_overflow_runs = 0;
    out_t        want_read;

    function automatic void hist_close_run();
        logic [32:0] sum;
        if (!row_open) return;
        if (run_length >= {16'd0, min_len}) begin
            if (run_value < NUM_VALUES) begin
                if (count_table[run_value] != SAT32) count_table[run_value]++;
                sum = {1'b0, total_table[run_value]} + {1'b0, run_length};
                total_table[run_value] = (sum >= {1'b0, SAT32}) ? SAT32 : sum[31:0];
                n_recorded++;
            end else begin
                overflow_flag = 1'b1;
                n_overflow_runs++;
            end
        end
        row_open = 1'b0;
    endfunction

    function automatic void hist_clear_all();
        last_row      = 32'd1;
        last_col      = '0;
        row_open      = 1'b0;
        run_value     = '0;
        run_length    = '0;
        overflow_flag = 1'b0;
        for (int k = 0; k < NUM_VALUES; k++) begin
            count_table[k] = '0;
            total_table[k] = '0;
        end
    endfunction

    // Advances the histogram state by one transaction; returns 1 when a read answers.
    function automatic bit hist_step(input in_t item, output out_t res);
        logic [31:0] delta;
        res = '0;
        case (item.opcode)
            OP_POINT: begin
                if (row_open && item.row_index != last_row) hist_close_run();
                last_row = item.row_index;
                if (!row_open) begin
                    row_open   = 1'b1;
                    run_value  = item.col_index;
                    run_length = 32'd1;
                end else begin
                    delta = item.col_index - last_col;
                    if (delta == run_value) begin
                        if (run_length != SAT32) run_length++;
                    end else begin
                        hist_close_run();
                        row_open   = 1'b1;
                        run_value  = delta;
                        run_length = 32'd1;
                    end
                end
                last_col = item.col_index;
                return 1'b0;
            end
            OP_FLUSH: begin
                hist_close_run();
                return 1'b0;
            end
            OP_READ: begin
                if (32'(item.entry_index) < NUM_VALUES) begin
                    res.run_count = count_table[item.entry_index];
                    res.run_total = total_table[item.entry_index];
                end
                res.value_overflow = overflow_flag;
                return 1'b1;
            end
            OP_CLEAR: begin
                hist_clear_all();
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, exp);
        err_count++;
    endtask

    task automatic send_item(input in_t item, input logic fixed, input out_t want);
        out_t res;
        bit   answers;
        if (gaps_on && burst_left == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end else if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        answers = hist_step(item, res);
        if (answers) expected_reads.push_back(fixed ? want : res);
        n_items++;
    endtask

    // Holds the sender off until every read has been answered and the pipeline is empty.
    task automatic drain_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_reads.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_min_len(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        min_len = value;
    endtask

    // Mostly well-formed rows of equal-delta runs, with some flushes, reads, clears and noise.
    task automatic next_random_item(output in_t item);
        int pick;
        pick = $urandom_range(0, 99);
        item.opcode      = OP_POINT;
        item.row_index   = $urandom;
        item.col_index   = $urandom;
        item.entry_index = 8'($urandom);
        if (pick < 1) begin
            item.opcode = OP_CLEAR;
        end else if (pick < 7) begin
            item.opcode = OP_FLUSH;
        end else if (pick < 20) begin
            item.opcode = OP_READ;
            if ($urandom_range(0, 1) == 0) item.entry_index = 8'($urandom_range(0, 15));
        end else if (pick >= 26) begin
            if (gen_left == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    gen_row = ($urandom_range(0, 9) == 0) ? $urandom
                                                          : gen_row + $urandom_range(1, 3);
                    gen_col = '0;
                end
                pick = $urandom_range(0, 19);
                gen_delta = (pick < 14) ? $urandom_range(0, 15) :
                            (pick < 17) ? $urandom_range(16, 255) : $urandom_range(256, 5000);
                gen_left = $urandom_range(1, 9);
            end
            gen_col = gen_col + gen_delta;
            gen_left--;
            item.row_index = gen_row;
            item.col_index = gen_col;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        rx_tick <= rx_tick + 6'd1;
        if (rx_tick == '0) begin
            rx_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
        end else begin
            rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
        end
        m_ready <= !stall_on || rx_pattern[0];
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_reads++;
            if (expected_reads.size() == 0) begin
                report_mismatch("result with no read pending", m_data.run_count, '0);
            end else begin
                want_read = expected_reads.pop_front();
                if (m_data.run_count !== want_read.run_count)
                    report_mismatch("run_count", m_data.run_count, want_read.run_count);
                if (m_data.run_total !== want_read.run_total)
                    report_mismatch("run_total", m_data.run_total, want_read.run_total);
                if (m_data.value_overflow !== want_read.value_overflow)
                    report_mismatch("value_overflow", 32'(m_data.value_overflow),
                                    32'(want_read.value_overflow));
            end
        end
    end

    // Watchdog: too many cycles without any transaction on either channel ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog expired with %0d reads outstanding.", expected_reads.size());
                $display("delta_run_length_histogram_tb failed");
                $finish;
            end
        end
    end

    initial begin
        in_t item;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = MIN_RUN_RESET;
        s_valid     = 1'b0;
        s_data      = '0;
        gaps_on     = 1'b1;
        stall_on    = 1'b1;
        min_len     = MIN_RUN_RESET;
        hist_clear_all();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
            send_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_block();
            write_min_len(MIN_LEN_SETTINGS[p]);
            gaps_on  = (p % 3 != 1);
            stall_on = (p != 1) && (p % 3 != 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                next_random_item(item);
                send_item(item, 1'b0, '0);
                if ($urandom_range(0, 299) == 0) drain_block();
            end
        end

        drain_block();
        if (expected_reads.size() != 0)
            report_mismatch("reads never answered", 32'(expected_reads.size()), '0);
        $display("Sent %0d transactions over %0d run-length settings; %0d reads answered.",
                 n_items, NUM_PHASES + 1, n_reads);
        $display("%0d runs entered the histogram and %0d runs set the overflow flag.",
                 n_recorded, n_overflow_runs);
        if (err_count == 0) begin
            $display("delta_run_length_histogram_tb passed");
        end else begin
            $display("delta_run_length_histogram_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/dlh_pkg.sv
hdl/dlh_stream.sv
hdl/dlh_table.sv
hdl/dlh_out_fifo.sv
hdl/delta_run_length_histogram.sv
test/delta_run_length_histogram_tb.sv
